### hw/rtl/error_metric_accumulator_macros.svh
// Assertion macros shared by the error metric accumulator RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ERROR_METRIC_ACCUMULATOR_MACROS_SVH
`define ERROR_METRIC_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define EMAC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("emac check failed");
// Condition that must never be true outside reset.
`define EMAC_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("emac forbidden condition seen");
`else
`define EMAC_ASSERT(lbl, clk, rst, prop)
`define EMAC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### hw/rtl/emac_pkg.sv
// Package for the error metric accumulator: widths, codes and the job record.
// Depends on nothing; used by every module of the block.
package emac_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int MAX_PAIRS = 4096;
  localparam int CNT_W     = 13;
  localparam int SUM_W     = 36;
  localparam int SAE_W     = 37;
  localparam int SSE_W     = 62;
  localparam int SSQ_W     = 58;
  localparam int MODE_W    = 3;
  localparam int ST_W      = 2;
  localparam int VAL_W     = 64;
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = 2;

  localparam logic [MODE_W-1:0] MODE_MSE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAPE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RMSE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_R2   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MISM = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PRE  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_ZDEN = 2'd1;
  localparam logic [ST_W-1:0] ST_LEN  = 2'd2;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd3;

  localparam logic [VAL_W-1:0] VAL_ONE = 64'h0000_0001_0000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // Everything the back end needs to finish one data set.
  typedef struct packed {
    logic [CNT_W-1:0]           n;
    logic signed [SUM_W-1:0]    sum_ref;
    logic signed [SUM_W-1:0]    sum_apx;
    logic [SAE_W-1:0]           sae;
    logic [SSE_W-1:0]           sse;
    logic [SSQ_W-1:0]           ssr;
    logic [SSQ_W-1:0]           ssa;
    logic [CNT_W-1:0]           mism;
    logic signed [SAMPLE_W-1:0] first;
  } job_t;

endpackage

### hw/rtl/emac_front.sv
// Front end: takes sample pairs, keeps the running sums, emits a job per set.
// Depends on emac_pkg.
module emac_front import emac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] reference_sample,
  input  logic signed [SAMPLE_W-1:0] approx_sample,
  input  logic                       last_pair,
  input  logic [QCNT_W-1:0]          q_count,
  output logic                       job_push,
  output job_t                       job
);

  logic                       accept;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       close_in;

  // Stage A: operands prepared, one pair.
  logic                       a_valid;
  logic                       a_close;
  logic                       a_first;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [SAMPLE_W-1:0] a_a;
  logic [SAMPLE_W:0]          a_dmag;
  logic [SAMPLE_W-1:0]        a_rmag;
  logic [SAMPLE_W-1:0]        a_amag;
  logic                       a_mis;
  logic signed [SAMPLE_W:0]   diff;

  // Stage B: accumulators.
  logic [CNT_W-1:0]           n;
  logic signed [SUM_W-1:0]    sum_ref;
  logic signed [SUM_W-1:0]    sum_apx;
  logic [SAE_W-1:0]           sae;
  logic [SSE_W-1:0]           sse;
  logic [SSQ_W-1:0]           ssr;
  logic [SSQ_W-1:0]           ssa;
  logic [CNT_W-1:0]           mism;
  logic signed [SAMPLE_W-1:0] first;
  job_t                       acc_next;

  // A closing pair in stage A will take a queue slot next cycle.
  assign full = (q_count == QCNT_W'(QDEPTH)) ||
                ((q_count == QCNT_W'(QDEPTH - 1)) && a_valid && a_close);
  assign accept   = push && !full;
  assign cnt_inc  = cnt + 1'b1;
  assign close_in = last_pair || (cnt_inc == CNT_W'(MAX_PAIRS));
  assign diff     = (SAMPLE_W+1)'(reference_sample) - (SAMPLE_W+1)'(approx_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        cnt <= close_in ? '0 : cnt_inc;
      end
    end
    a_close <= close_in;
    a_first <= (cnt == '0);
    a_r     <= reference_sample;
    a_a     <= approx_sample;
    a_dmag  <= diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
    a_rmag  <= reference_sample[SAMPLE_W-1] ? SAMPLE_W'(-reference_sample)
                                            : SAMPLE_W'(reference_sample);
    a_amag  <= approx_sample[SAMPLE_W-1] ? SAMPLE_W'(-approx_sample)
                                         : SAMPLE_W'(approx_sample);
    a_mis   <= (reference_sample != approx_sample);
  end

  always_comb begin
    acc_next.n       = n + 1'b1;
    acc_next.sum_ref = sum_ref + SUM_W'(a_r);
    acc_next.sum_apx = sum_apx + SUM_W'(a_a);
    acc_next.sae     = sae + SAE_W'(a_dmag);
    acc_next.sse     = sse + SSE_W'(a_dmag * a_dmag);
    acc_next.ssr     = ssr + SSQ_W'(a_rmag * a_rmag);
    acc_next.ssa     = ssa + SSQ_W'(a_amag * a_amag);
    acc_next.mism    = mism + CNT_W'(a_mis);
    acc_next.first   = a_first ? a_a : first;
  end

  assign job      = acc_next;
  assign job_push = a_valid && a_close;

  always_ff @(posedge clk) begin
    if (rst || job_push) begin
      n       <= '0;
      sum_ref <= '0;
      sum_apx <= '0;
      sae     <= '0;
      sse     <= '0;
      ssr     <= '0;
      ssa     <= '0;
      mism    <= '0;
      first   <= '0;
    end else if (a_valid) begin
      n       <= acc_next.n;
      sum_ref <= acc_next.sum_ref;
      sum_apx <= acc_next.sum_apx;
      sae     <= acc_next.sae;
      sse     <= acc_next.sse;
      ssr     <= acc_next.ssr;
      ssa     <= acc_next.ssa;
      mism    <= acc_next.mism;
      first   <= acc_next.first;
    end
  end

endmodule

### hw/rtl/emac_queue.sv
// Short job queue between the front end and the back end.
// Depends on emac_pkg.
module emac_queue import emac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  job_t              wr_job,
  input  logic              rd,
  output job_t              rd_job,
  output logic              q_empty,
  output logic [QCNT_W-1:0] q_count
);

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign q_empty = (q_count == '0);
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      q_count <= q_count + QCNT_W'(wr) - QCNT_W'(rd);
    end
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

### hw/rtl/emac_back.sv
// Back end: turns a job into one metric with a shared multiply, divide and root.
// Depends on emac_pkg and error_metric_accumulator_macros.svh.
`include "error_metric_accumulator_macros.svh"
module emac_back import emac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [MODE_W-1:0]       metric_mode,
  input  logic                    job_valid,
  input  job_t                    job,
  output logic                    job_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic signed [VAL_W-1:0] metric_value,
  output logic [ST_W-1:0]         status,
  output logic [CNT_W-1:0]        pair_count
);

  localparam int W      = 72;   // numerator and denominator width
  localparam int XW     = W + 32;
  localparam int DCNT_W = $clog2(XW);
  localparam int CH_W   = 12;
  localparam int SQ_IT  = 48;
  localparam int SCNT_W = $clog2(SQ_IT);
  localparam int SR_W   = SQ_IT + 2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state;
  job_t                cur;
  logic [MODE_W-1:0]   mode;
  logic [W-1:0]        num;
  logic [W-1:0]        den;
  logic [1:0]          mul_idx;
  logic [1:0]          chunk;
  logic [XW-1:0]       dx;
  logic [W-1:0]        rem;
  logic [VAL_W-1:0]    q;
  logic                ovf;
  logic [DCNT_W-1:0]   dcnt;
  logic [2*SQ_IT-1:0]  sx;
  logic [SR_W-1:0]     srem;
  logic [SQ_IT-1:0]    sres;
  logic [SCNT_W-1:0]   scnt;
  logic [VAL_W-1:0]    val;
  logic [ST_W-1:0]     st;
  logic                res_valid;

  logic [SUM_W-1:0]    rm;
  logic [SUM_W-1:0]    am;
  logic [SSQ_W-1:0]    mul_a;
  logic [SUM_W-1:0]    mul_b;
  logic [CH_W-1:0]     mul_ch;
  logic [SSQ_W+CH_W-1:0] prod;
  logic [W-1:0]        term;
  logic [W:0]          rem_sh;
  logic [W:0]          rem_dif;
  logic [VAL_W-1:0]    q_new;
  logic                ovf_new;
  logic [SR_W+1:0]     srem_sh;
  logic [SR_W+1:0]     strial;
  logic                slot_free;

  assign rm = cur.sum_ref[SUM_W-1] ? SUM_W'(-cur.sum_ref) : SUM_W'(cur.sum_ref);
  assign am = cur.sum_apx[SUM_W-1] ? SUM_W'(-cur.sum_apx) : SUM_W'(cur.sum_apx);

  // R2 products, one 12-bit slice of the multiplier operand per cycle.
  always_comb begin
    unique case (mul_idx)
      2'd0:    begin mul_a = cur.ssa;          mul_b = SUM_W'(cur.n); end
      2'd1:    begin mul_a = SSQ_W'(rm);       mul_b = rm;            end
      2'd2:    begin mul_a = SSQ_W'(am);       mul_b = rm;            end
      default: begin mul_a = cur.ssr;          mul_b = SUM_W'(cur.n); end
    endcase
    case (chunk)
      2'd0:    mul_ch = mul_b[CH_W-1:0];
      2'd1:    mul_ch = mul_b[2*CH_W-1:CH_W];
      default: mul_ch = mul_b[3*CH_W-1:2*CH_W];
    endcase
    prod = mul_a * mul_ch;
    case (chunk)
      2'd0:    term = W'(prod);
      2'd1:    term = {prod[W-CH_W-1:0], {CH_W{1'b0}}};
      default: term = {prod[W-2*CH_W-1:0], {(2*CH_W){1'b0}}};
    endcase
  end

  // One restoring division step per cycle. The first step takes the top
  // numerator bit directly, before the shift register has been loaded.
  always_comb begin
    rem_sh  = {rem, (dcnt == '0) ? num[W-1] : dx[XW-1]};
    rem_dif = rem_sh - {1'b0, den};
    ovf_new = ovf | q[VAL_W-1];
    q_new   = {q[VAL_W-2:0], !rem_dif[W]};
  end

  // One result bit of the square root per cycle, two radicand bits in.
  assign srem_sh = {srem, sx[2*SQ_IT-1 -: 2]};
  assign strial  = (SR_W+2)'({sres, 2'b01});

  assign slot_free = !res_valid || pop;
  assign job_pop   = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur     <= job;
            mode    <= metric_mode;
            mul_idx <= '0;
            chunk   <= '0;
            dcnt    <= '0;
            ovf     <= 1'b0;
            q       <= '0;
            rem     <= '0;
            st      <= ST_OK;
            case (metric_mode)
              MODE_MSE, MODE_RMSE: begin
                num   <= W'(job.sse);
                den   <= W'({job.n, 24'b0});
                state <= S_DIV;
              end
              MODE_MAE: begin
                num   <= W'(job.sae);
                den   <= W'({job.n, 12'b0});
                state <= S_DIV;
              end
              MODE_MAPE: begin
                num   <= W'(job.sae);
                den   <= W'($unsigned(job.sum_ref[SUM_W-1] ? -job.sum_ref
                                                           : job.sum_ref));
                state <= S_DIV;
              end
              MODE_R2: begin
                num   <= '0;
                den   <= '0;
                state <= S_MUL;
              end
              MODE_MISM: begin
                num   <= W'(job.mism);
                den   <= W'(job.n);
                state <= S_DIV;
              end
              MODE_PRE: begin
                if (job.n != CNT_W'(1)) begin
                  val <= VAL_ONE;
                  st  <= ST_LEN;
                end else begin
                  val <= {{(VAL_W-SAMPLE_W-20){job.first[SAMPLE_W-1]}}, job.first, 20'b0};
                end
                state <= S_DONE;
              end
              default: begin
                val   <= VAL_ONE;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          // num = n*ssa + R^2 - 2*R*A, den = n*ssr - R^2
          case (mul_idx)
            2'd0: num <= num + term;
            2'd1: begin
              num <= num + term;
              den <= den - term;
            end
            2'd2: begin
              if (cur.sum_ref[SUM_W-1] ^ cur.sum_apx[SUM_W-1]) begin
                num <= num + {term[W-2:0], 1'b0};
              end else begin
                num <= num - {term[W-2:0], 1'b0};
              end
            end
            default: den <= den + term;
          endcase
          if (chunk == 2'd2) begin
            chunk   <= '0;
            mul_idx <= mul_idx + 1'b1;
            if (mul_idx == 2'd3) begin
              state <= S_DIV;
            end
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        S_DIV: begin
          if (dcnt == '0 && den == '0) begin
            val   <= '0;
            st    <= ST_ZDEN;
            state <= S_DONE;
          end else begin
            if (dcnt == '0) begin
              dx <= {num[W-2:0], 32'b0, 1'b0};
            end else begin
              dx <= {dx[XW-2:0], 1'b0};
            end
            rem  <= rem_dif[W] ? rem_sh[W-1:0] : rem_dif[W-1:0];
            q    <= q_new;
            ovf  <= ovf_new;
            dcnt <= dcnt + 1'b1;
            if (dcnt == DCNT_W'(XW - 1)) begin
              if (ovf_new || q_new[VAL_W-1]) begin
                val   <= VAL_MAX;
                st    <= ST_SAT;
                state <= S_DONE;
              end else if (mode == MODE_RMSE) begin
                sx    <= {q_new, 32'b0};
                srem  <= '0;
                sres  <= '0;
                scnt  <= '0;
                state <= S_SQRT;
              end else begin
                val   <= q_new;
                state <= S_DONE;
              end
            end
          end
        end
        S_SQRT: begin
          sx <= {sx[2*SQ_IT-3:0], 2'b00};
          if (srem_sh >= strial) begin
            srem <= SR_W'(srem_sh - strial);
            sres <= {sres[SQ_IT-2:0], 1'b1};
          end else begin
            srem <= SR_W'(srem_sh);
            sres <= {sres[SQ_IT-2:0], 1'b0};
          end
          scnt <= scnt + 1'b1;
          if (scnt == SCNT_W'(SQ_IT - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            res_valid    <= 1'b1;
            metric_value <= (mode == MODE_RMSE && st == ST_OK)
                            ? VAL_W'(sres) : val;
            status       <= st;
            pair_count   <= cur.n;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !res_valid;

  `EMAC_ASSERT(sat_value_a, clk, rst, res_valid && status == ST_SAT |-> metric_value == VAL_MAX)
  `EMAC_ASSERT_NEVER(zden_value_a, clk, rst, res_valid && status == ST_ZDEN && metric_value != '0)
  `EMAC_ASSERT(len_count_a, clk, rst, res_valid && status == ST_LEN |-> pair_count != CNT_W'(1))

endmodule

### hw/rtl/error_metric_accumulator.sv
// Top level of the error metric accumulator: config register and wiring.
// Depends on emac_pkg, emac_front, emac_queue and emac_back.
//
// Usage. Sample pairs enter through a queue-style port: a pair transfers
// on a rising edge with push high and full low, one pair per cycle at most.
// A data set closes on the pair with last_pair set, or on the 4096th pair.
// Each closed set yields one result (metric_value, status, pair_count),
// visible while empty is low and transferred on an edge with pop high.
// The metric is chosen by metric_mode, written through the cfg channel
// (cfg_ready is always high); write it only while the block is idle, as
// the block itself does not enforce this. After the closing pair, the
// precomputed and undefined modes go straight to the done step; the
// divided metrics run a restoring division, one quotient bit per cycle
// over 104 steps; R2 first builds its four products from 12-bit slices;
// and RMSE then takes a square root, one root bit per cycle. Within a set,
// pairs are taken every cycle while full is low; a two-entry job queue lets
// the front run up to two finished sets ahead of the back end, then full
// rises until a slot frees. When the receiver holds pop low, the finished
// result waits in the output register and the back end stops at its
// done step. Reset clears all sums and the queue, empties the output
// register and sets metric_mode to MSE.
module error_metric_accumulator import emac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] reference_sample,
  input  logic signed [SAMPLE_W-1:0] approx_sample,
  input  logic                       last_pair,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [VAL_W-1:0]    metric_value,
  output logic [ST_W-1:0]            status,
  output logic [CNT_W-1:0]           pair_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MODE_W-1:0]          cfg_data
);

  logic [MODE_W-1:0] metric_mode;
  logic              job_push;
  job_t              front_job;
  job_t              back_job;
  logic              job_pop;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  // The mode register takes every transfer on the configuration channel.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_MSE;
    end else if (cfg_valid && cfg_ready) begin
      metric_mode <= cfg_data;
    end
  end

  emac_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .reference_sample (reference_sample),
    .approx_sample    (approx_sample),
    .last_pair        (last_pair),
    .q_count          (q_count),
    .job_push         (job_push),
    .job              (front_job)
  );

  emac_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (front_job),
    .rd      (job_pop),
    .rd_job  (back_job),
    .q_empty (q_empty),
    .q_count (q_count)
  );

  emac_back u_back (
    .clk          (clk),
    .rst          (rst),
    .metric_mode  (metric_mode),
    .job_valid    (!q_empty),
    .job          (back_job),
    .job_pop      (job_pop),
    .pop          (pop),
    .empty        (empty),
    .metric_value (metric_value),
    .status       (status),
    .pair_count   (pair_count)
  );

endmodule
